### sv/mms_pkg.sv
// shared types, codes and constants of the min/max stack
// no dependencies; imported by every module of the block but mms_ram
`timescale 1ns / 1ps

package mms_pkg;

    // default number of stack entries
    localparam int MMS_DEPTH = 64;

    localparam int VAL_W   = 32;
    localparam int CNT_OUT_W = 7;

    // operation codes carried in s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes carried in m_tuser
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_PUSH_FULL  = 2'd2
    } status_t;

    // one stack entry: value with the running max and min down to the bottom
    typedef struct packed {
        logic signed [VAL_W-1:0] min_val;
        logic signed [VAL_W-1:0] max_val;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // result word layout: popped, count, max, min, padded to whole bytes
    localparam int RES_W  = VAL_W + CNT_OUT_W + VAL_W + VAL_W;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic signed [VAL_W-1:0] EMPTY_MARK = '1;

    function automatic logic [TDATA_W-1:0] pack_result(
        input logic signed [VAL_W-1:0] popped,
        input logic [CNT_OUT_W-1:0]    cnt,
        input logic signed [VAL_W-1:0] max_v,
        input logic signed [VAL_W-1:0] min_v
    );
        logic [TDATA_W-1:0] w;
        w = '0;
        w[RES_W-1:0] = {min_v, max_v, cnt, popped};
        return w;
    endfunction

endpackage

### sv/stack_with_count_max_min.sv
// Min/max stack: bounded LIFO of signed 32-bit values.
//
// Input channel s_*: one word per operation. s_tuser[0] selects push (0) or
// pop (1), s_tdata[31:0] is the value to push.
// Result channel m_*: one word per operation with the status in m_tuser and
// the popped value, entry count, maximum and minimum after the operation in
// m_tdata. Max and min read -1 when the stack is empty.
//
// Every entry lives in a ram together with the running max and min of itself and
// the entries below it; the top entry is also held in registers so a push needs
// no memory read. A push, a pop to empty, or a rejected operation forms its result
// straight from the top registers. A pop that leaves entries behind passes through
// ST_POP_LOAD, since the new top must come back from the ram's registered read.
//
// The result sits in an output register; a new word is taken while that
// register is empty or being drained and no pop is loading its new top. If the
// receiver stalls, the result holds and s_tready drops until it is taken.
// Reset empties the stack (count zero) and clears m_tvalid; ram contents are
// not cleared, since only entries below the count are ever read.
// A push on a full stack and a pop on an empty one leave the stack unchanged.
`timescale 1ns / 1ps

module stack_with_count_max_min
    import mms_pkg::*;
#(
    parameter int DEPTH = MMS_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VAL_W-1:0]   s_tdata,   // push_value[31:0]
    input  logic [0:0]         s_tuser,   // operation[0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // popped_value[31:0], entry_count[38:32],
                                          // max_value[70:39], min_value[102:71]
    output logic [1:0]         m_tuser    // status[1:0]
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_POP_LOAD
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    entry_t               top_reg, top_next;
    logic signed [VAL_W-1:0] popped_reg, popped_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;
    entry_t               push_entry;
    logic [CNT_W-1:0]     below_idx;
    logic [31:0]          cnt_wide;
    logic [31:0]          cnt_wide_next;
    logic                 s_accept;
    logic                 is_full;
    logic                 is_empty;

    assign s_accept  = s_tvalid && s_tready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign below_idx = count_reg - CNT_W'(2);
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_raddr = below_idx[AW-1:0];
    assign rd_entry  = entry_t'(ram_rdata);
    assign cnt_wide  = 32'(count_reg);
    assign cnt_wide_next = 32'(count_next);

    // entry storage
    mms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // new entry for a push, built from the top registers
    mms_minmax u_minmax (
        .below     (top_reg),
        .has_below (!is_empty),
        .value     (s_tdata),
        .entry     (push_entry)
    );

    // operation sequencing and result forming
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        popped_next   = popped_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == OP_PUSH) begin
                        if (is_full) begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = STAT_PUSH_FULL;
                            m_tdata_next  = pack_result('0, cnt_wide[CNT_OUT_W-1:0],
                                                        top_reg.max_val, top_reg.min_val);
                        end else begin
                            ram_we        = 1'b1;
                            top_next      = push_entry;
                            count_next    = count_reg + CNT_W'(1);
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = STAT_OK;
                            m_tdata_next  = pack_result('0, cnt_wide_next[CNT_OUT_W-1:0],
                                                        push_entry.max_val,
                                                        push_entry.min_val);
                        end
                    end else begin
                        if (is_empty) begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = STAT_POP_EMPTY;
                            m_tdata_next  = pack_result('0, '0, EMPTY_MARK, EMPTY_MARK);
                        end else if (count_reg == CNT_W'(1)) begin
                            count_next    = '0;
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = STAT_OK;
                            m_tdata_next  = pack_result(top_reg.value, '0,
                                                        EMPTY_MARK, EMPTY_MARK);
                        end else begin
                            // fetch the entry that becomes the new top
                            ram_re      = 1'b1;
                            count_next  = count_reg - CNT_W'(1);
                            popped_next = top_reg.value;
                            state_next  = ST_POP_LOAD;
                        end
                    end
                end
            end
            ST_POP_LOAD: begin
                top_next      = rd_entry;
                m_tvalid_next = 1'b1;
                m_tuser_next  = STAT_OK;
                m_tdata_next  = pack_result(popped_reg, cnt_wide[CNT_OUT_W-1:0],
                                            rd_entry.max_val, rd_entry.min_val);
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, stack top and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        top_reg     <= top_next;
        popped_reg  <= popped_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sv/mms_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/mms_minmax.sv
// builds the entry written by a push: value plus running max and min
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_minmax
    import mms_pkg::*;
(
    input  entry_t                  below,
    input  logic                    has_below,
    input  logic signed [VAL_W-1:0] value,
    output entry_t                  entry
);

    // fold the new value into the running max and min of the entry below
    always_comb begin
        entry.value   = value;
        entry.max_val = value;
        entry.min_val = value;
        if (has_below) begin
            if (below.max_val > value) begin
                entry.max_val = below.max_val;
            end
            if (below.min_val < value) begin
                entry.min_val = below.min_val;
            end
        end
    end

endmodule

### tb/stack_with_count_max_min_tb.sv
// self-checking testbench for the min/max stack: directed and random push/pop words
// depends on mms_pkg and stack_with_count_max_min; a shadow stack predicts every result
`timescale 1ns / 1ps

module stack_with_count_max_min_tb;
    import mms_pkg::*;

    localparam int STACK_DEPTH  = MMS_DEPTH;
    localparam int TOTAL_ITEMS  = 1720;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;

    // one predicted result word
    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] popped;
        logic [CNT_OUT_W-1:0]    count;
        logic signed [VAL_W-1:0] max_v;
        logic signed [VAL_W-1:0] min_v;
    } stack_result_t;

    // shadow stack with running max/min, and the queue of results still owed
    class stack_tracker;
        entry_t        shadow[STACK_DEPTH];
        int            used;
        stack_result_t owed_results[$];
        int            errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // predict the result of one accepted operation
        function void note_op(input logic op, input logic signed [VAL_W-1:0] val);
            stack_result_t           r;
            entry_t                  e;
            logic signed [VAL_W-1:0] below_max;
            logic signed [VAL_W-1:0] below_min;
            r.status = STAT_OK;
            r.popped = '0;
            if (op == OP_PUSH) begin
                if (used >= STACK_DEPTH) begin
                    r.status = STAT_PUSH_FULL;
                end else begin
                    e.value   = val;
                    e.max_val = val;
                    e.min_val = val;
                    if (used > 0) begin
                        below_max = shadow[used-1].max_val;
                        below_min = shadow[used-1].min_val;
                        if (below_max > val) e.max_val = below_max;
                        if (below_min < val) e.min_val = below_min;
                    end
                    shadow[used] = e;
                    used++;
                end
            end else begin
                if (used == 0) begin
                    r.status = STAT_POP_EMPTY;
                end else begin
                    used--;
                    r.popped = shadow[used].value;
                end
            end
            if (used > 0) begin
                r.max_v = shadow[used-1].max_val;
                r.min_v = shadow[used-1].min_val;
            end else begin
                r.max_v = EMPTY_MARK;
                r.min_v = EMPTY_MARK;
            end
            r.count = CNT_OUT_W'(used);
            owed_results.push_back(r);
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(input logic [1:0] tuser, input logic [TDATA_W-1:0] tdata);
            stack_result_t           r;
            logic signed [VAL_W-1:0] got_pop;
            logic [CNT_OUT_W-1:0]    got_cnt;
            logic signed [VAL_W-1:0] got_max;
            logic signed [VAL_W-1:0] got_min;
            got_pop = tdata[31:0];
            got_cnt = tdata[38:32];
            got_max = tdata[70:39];
            got_min = tdata[102:71];
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected result word status %0d count %0d",
                             tuser, got_cnt);
                return;
            end
            r = owed_results.pop_front();
            if (tuser !== r.status || got_pop !== r.popped || got_cnt !== r.count ||
                got_max !== r.max_v || got_min !== r.min_v) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: status %0d/%0d popped %0d/%0d count %0d/%0d ",
                              "max %0d/%0d min %0d/%0d (expected/actual)"},
                             r.status, tuser, r.popped, got_pop, r.count, got_cnt,
                             r.max_v, got_max, r.min_v, got_min);
            end
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata  = '0;
    logic [0:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    stack_tracker tracker;
    int           cycles      = 0;
    int           items_sent  = 0;
    int           depth_est   = 0;
    int           burst_left  = 4;
    int           no_gap_left = 0;
    bit           tx_live     = 1'b0;
    bit           long_hold   = 1'b0;

    stack_with_count_max_min uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // watch both channels: predict on accepted input, check on accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.note_op(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
        end
    end

    // receiver: stretches of stall patterns, plus a long hold when asked
    initial begin
        int mode;
        int len;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 80);
            repeat (len) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= (cycles % 3 != 0);
                endcase
                @(posedge aclk);
                if (long_hold) break;
            end
        end
    end

    // offer one word and wait for it to be taken; bursts end in a random gap
    task automatic offer(input logic op, input logic [VAL_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                tx_live = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic push_word(input logic [VAL_W-1:0] val);
        if (depth_est < STACK_DEPTH) depth_est++;
        offer(OP_PUSH, val);
    endtask

    task automatic pop_word();
        if (depth_est > 0) depth_est--;
        offer(OP_POP, $urandom());
    endtask

    // sender pause until every owed result has come back
    // it first lets the monitor note the last accepted word
    task automatic wait_drained();
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
        end
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // push values lean on extremes and a narrow range so ties happen
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    task automatic fill_up();
        while (depth_est < STACK_DEPTH) push_word(pick_value());
        repeat ($urandom_range(1, 3)) push_word(pick_value());
    endtask

    task automatic drain_out();
        while (depth_est > 0) pop_word();
        repeat ($urandom_range(1, 3)) pop_word();
    endtask

    initial begin
        int n;
        int push_pct;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pop on empty, extreme values, ties, back to empty
        pop_word();
        push_word(32'h7FFF_FFFF);
        push_word(32'h8000_0000);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0001);
        repeat (6) pop_word();
        push_word(32'h8000_0000);
        pop_word();
        push_word(32'h0000_0005);
        push_word(32'h0000_0005);
        push_word(32'hAAAA_5555);
        push_word(32'h5555_AAAA);
        repeat (5) pop_word();
        wait_drained();

        // fill while the receiver holds off, so the input stalls; then push on full, drain and pop on empty
        long_hold   = 1'b1;
        no_gap_left = 120;
        fill_up();
        drain_out();
        wait_drained();

        // random phases: fill, drain, biased mixes and noise
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 5))
                0: fill_up();
                1: drain_out();
                2, 3: begin
                    n        = $urandom_range(10, 60);
                    push_pct = $urandom_range(20, 80);
                    repeat (n) begin
                        if ($urandom_range(0, 99) < push_pct) push_word(pick_value());
                        else pop_word();
                    end
                end
                default: begin
                    repeat ($urandom_range(5, 20)) begin
                        if ($urandom_range(0, 1) != 0) push_word($urandom());
                        else pop_word();
                    end
                end
            endcase
            if ($urandom_range(0, 9) == 0) wait_drained();
            if ($urandom_range(0, 29) == 0) begin
                long_hold   = 1'b1;
                no_gap_left = 80;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
